// ===== rtl/core/asl_pkg.sv =====
`default_nettype none

package asl_pkg;

    // Lexer mode, held between source bytes.
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_NAME  = 3'd1,
        MODE_INT   = 3'd2,
        MODE_MINUS = 3'd3,
        MODE_CR    = 3'd4,
        MODE_ERROR = 3'd5
    } mode_t;

    // Token kind codes as they appear on token_kind.
    typedef enum logic [2:0] {
        KIND_CHAR     = 3'd0,
        KIND_NAME_END = 3'd1,
        KIND_INT      = 3'd2,
        KIND_NEWLINE  = 3'd3,
        KIND_COLON    = 3'd4,
        KIND_END      = 3'd5,
        KIND_ERROR    = 3'd6
    } kind_t;

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    // Most result words one source byte can cause.
    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] character;
        logic       first;
        logic [7:0] value;
        logic       last;
    } res_t;

    // Result words produced by one accepted byte, in order.
    typedef struct packed {
        logic [1:0] count;
        res_t [MAX_RESULTS-1:0] entry;
    } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/asl_step.sv =====
`default_nettype none

module asl_step (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   source_byte,
    input  wire logic         final_byte,
    output asl_pkg::push_t    push
);
    import asl_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [7:0] acc_reg, acc_next;
    logic       neg_reg, neg_next;

    function automatic res_t mk(kind_t k, logic [7:0] c, logic f, logic [7:0] v);
        res_t r;
        r.kind      = k;
        r.character = c;
        r.first     = f;
        r.value     = v;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] mul10_add(logic [7:0] a, logic [7:0] c);
        logic [3:0] d;
        d = 4'(c - CH_ZERO);
        return {a[4:0], 3'b000} + {a[6:0], 1'b0} + {4'b0000, d};
    endfunction

    function automatic logic [7:0] signed_value(logic [7:0] a, logic neg);
        return neg ? (~a + 8'd1) : a;
    endfunction

    logic digit_hit, is_alpha, done;
    logic [1:0] n;
    res_t [MAX_RESULTS-1:0] res_v;

    assign digit_hit = (source_byte >= CH_ZERO) && (source_byte <= CH_NINE);
    assign is_alpha = ((source_byte >= CH_LOWER_A) && (source_byte <= CH_LOWER_Z))
                   || ((source_byte >= CH_UPPER_A) && (source_byte <= CH_UPPER_Z))
                   || (source_byte == CH_UNDERSCORE);

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        n         = 2'd0;
        done      = 1'b0;
        res_v     = '0;

        if (mode_reg == MODE_ERROR)
        begin
            // Bytes are dropped until the final byte brings the lexer back.
            if (final_byte)
            begin
                mode_next = MODE_IDLE;
                acc_next  = 8'd0;
                neg_next  = 1'b0;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_NAME:
                begin
                    if (is_alpha || digit_hit)
                    begin
                        res_v[n] = mk(KIND_CHAR, source_byte, 1'b0, 8'd0);
                        n = n + 2'd1;
                        done = 1'b1;
                    end
                    else
                    begin
                        res_v[n] = mk(KIND_NAME_END, 8'd0, 1'b0, 8'd0);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_INT:
                begin
                    if (digit_hit)
                    begin
                        acc_next = mul10_add(acc_reg, source_byte);
                        done = 1'b1;
                    end
                    else
                    begin
                        res_v[n] = mk(KIND_INT, 8'd0, 1'b0, signed_value(acc_reg, neg_reg));
                        n = n + 2'd1;
                        acc_next  = 8'd0;
                        neg_next  = 1'b0;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_MINUS:
                begin
                    if (digit_hit)
                    begin
                        acc_next  = mul10_add(8'd0, source_byte);
                        mode_next = MODE_INT;
                    end
                    else
                    begin
                        res_v[n] = mk(KIND_ERROR, 8'd0, 1'b0, 8'd0);
                        n = n + 2'd1;
                        mode_next = MODE_ERROR;
                    end
                    done = 1'b1;
                end
                MODE_CR:
                begin
                    if (source_byte == CH_LF)
                    begin
                        res_v[n] = mk(KIND_NEWLINE, 8'd0, 1'b0, 8'd0);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        res_v[n] = mk(KIND_ERROR, 8'd0, 1'b0, 8'd0);
                        n = n + 2'd1;
                        mode_next = MODE_ERROR;
                    end
                    done = 1'b1;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase

            if (!done)
            begin
                priority if ((source_byte == CH_SPACE) || (source_byte == CH_TAB))
                begin
                    mode_next = mode_next;
                end
                else if (is_alpha)
                begin
                    res_v[n] = mk(KIND_CHAR, source_byte, 1'b1, 8'd0);
                    n = n + 2'd1;
                    mode_next = MODE_NAME;
                end
                else if (digit_hit)
                begin
                    acc_next  = mul10_add(8'd0, source_byte);
                    neg_next  = 1'b0;
                    mode_next = MODE_INT;
                end
                else if (source_byte == CH_MINUS)
                begin
                    acc_next  = 8'd0;
                    neg_next  = 1'b1;
                    mode_next = MODE_MINUS;
                end
                else if (source_byte == CH_LF)
                begin
                    res_v[n] = mk(KIND_NEWLINE, 8'd0, 1'b0, 8'd0);
                    n = n + 2'd1;
                end
                else if (source_byte == CH_CR)
                begin
                    mode_next = MODE_CR;
                end
                else if (source_byte == CH_COLON)
                begin
                    res_v[n] = mk(KIND_COLON, 8'd0, 1'b0, 8'd0);
                    n = n + 2'd1;
                end
                else
                begin
                    res_v[n] = mk(KIND_ERROR, 8'd0, 1'b0, 8'd0);
                    n = n + 2'd1;
                    mode_next = MODE_ERROR;
                end
            end

            if (final_byte)
            begin
                // An open name is closed by the end word itself.
                priority if (mode_next == MODE_INT)
                begin
                    res_v[n] = mk(KIND_INT, 8'd0, 1'b0, signed_value(acc_next, neg_next));
                    n = n + 2'd1;
                    res_v[n] = mk(KIND_END, 8'd0, 1'b0, 8'd0);
                    n = n + 2'd1;
                end
                else if ((mode_next == MODE_MINUS) || (mode_next == MODE_CR))
                begin
                    res_v[n] = mk(KIND_ERROR, 8'd0, 1'b0, 8'd0);
                    n = n + 2'd1;
                end
                else if (mode_next != MODE_ERROR)
                begin
                    res_v[n] = mk(KIND_END, 8'd0, 1'b0, 8'd0);
                    n = n + 2'd1;
                end
                else
                begin
                    n = n;
                end
                mode_next = MODE_IDLE;
                acc_next  = 8'd0;
                neg_next  = 1'b0;
            end
        end

        if (n != 2'd0)
        begin
            res_v[n - 2'd1].last = 1'b1;
        end

        push.count = n;
        push.entry = res_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= 8'd0;
            neg_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/asl_res_fifo.sv =====
`default_nettype none

module asl_res_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_en,
    input  wire asl_pkg::push_t push,
    output logic                space,
    output logic                head_valid,
    input  wire logic           head_ready,
    output asl_pkg::res_t       head
);
    import asl_pkg::*;

    localparam int unsigned DEPTH = 4;

    res_t       mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] push_n;
    logic       pop;

    assign push_n     = push_en ? push.count : 2'd0;
    assign head_valid = (count_reg != 3'd0);
    assign head       = mem_reg[rd_ptr_reg];
    assign pop        = head_valid && head_ready;
    // Room for a full burst of results from the next byte.
    assign space      = (count_reg <= 3'd1);

    assign wr_ptr_next = wr_ptr_reg + push_n;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, push_n} - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (2'(i) < push_n)
            begin
                mem_reg[wr_ptr_reg + 2'(i)] <= push.entry[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/assembly_source_lexer_top.sv =====
`default_nettype none

// Streaming assembly source lexer. Source bytes arrive on the src channel, one
// word per byte, with final_byte set on the last byte of a source. Each byte is
// classified in the cycle it is accepted and the lexer state is updated at that
// same edge; the zero to three result words it causes are written into a
// four-entry result queue that drives the tok channel, one word per cycle while
// tok_ready is high. Names come out one character per word (name_first marks
// the first), followed by a name-end word unless the source ends inside the
// name; decimal integers, optionally negative, come out as one word modulo
// 256; LF or CR LF gives newline and ':' gives colon. A source is closed by an
// end word, or by a single error word on a bad byte, a lone CR or a dangling
// '-', after which bytes are dropped up to the final byte. run_last marks the
// last word caused by a byte. The block takes one byte per cycle as long as the
// tok side keeps up and each byte causes at most one word; a byte that causes
// two or three words holds src_ready low while the result queue drains, since
// the queue accepts a new byte only with room for three words.
module assembly_source_lexer_top (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       src_valid,
    output logic            src_ready,
    input  wire logic [7:0] source_byte,
    input  wire logic       final_byte,

    output logic            tok_valid,
    input  wire logic       tok_ready,
    output logic [2:0]      token_kind,
    output logic [7:0]      name_character,
    output logic            name_first,
    output logic [7:0]      integer_value,
    output logic            run_last
);
    import asl_pkg::*;

    logic  accept;
    push_t push;
    res_t  head;

    // A byte is taken only when the queue can hold every word it may cause.
    assign accept = src_valid && src_ready;

    asl_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .source_byte (source_byte),
        .final_byte  (final_byte),
        .push        (push)
    );

    asl_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (accept),
        .push       (push),
        .space      (src_ready),
        .head_valid (tok_valid),
        .head_ready (tok_ready),
        .head       (head)
    );

    assign token_kind     = head.kind;
    assign name_character = head.character;
    assign name_first     = head.first;
    assign integer_value  = head.value;
    assign run_last       = head.last;

endmodule

`default_nettype wire

// ===== rtl/core/asl_checker.sv =====
`default_nettype none

module asl_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       src_valid,
    input wire logic       src_ready,
    input wire logic [7:0] source_byte,
    input wire logic       final_byte,
    input wire logic       tok_valid,
    input wire logic       tok_ready,
    input wire logic [2:0] token_kind,
    input wire logic [7:0] name_character,
    input wire logic       name_first,
    input wire logic [7:0] integer_value,
    input wire logic       run_last
);
    import asl_pkg::*;

    // A waiting source byte stays offered and unchanged.
    a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_ready |=> src_valid && $stable(source_byte) && $stable(final_byte))
        else $error("source word changed while waiting");

    // A stalled result word stays offered.
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid)
        else $error("tok_valid dropped while stalled");

    // Name fields are only set on name character words.
    a_name_fields: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (token_kind != KIND_CHAR) |-> (name_character == 8'd0) && !name_first)
        else $error("name fields set on a non-character word");

    // The value field is only set on integer words.
    a_int_field: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (token_kind != KIND_INT) |-> (integer_value == 8'd0))
        else $error("integer_value set on a non-integer word");

    // End and error words close the words of a byte, and no kind lies past error.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && ((token_kind == KIND_END) || (token_kind == KIND_ERROR)
                      || (token_kind > KIND_ERROR))
        |-> run_last && (token_kind <= KIND_ERROR))
        else $error("end or error word not last, or bad kind");

endmodule

bind assembly_source_lexer_top asl_checker u_asl_checker (.*);

`default_nettype wire
